// ===== rtl/rvxe_pkg.sv =====
// Shared types and constants for the Euler XYZ vector rotation block.
package rvxe_pkg;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
  } rvxe_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               clipped;
  } rvxe_out_t;

  localparam int ATAN_ENTRIES = 30;
  localparam int RED_STAGES   = 7;

  localparam logic        [47:0] TWO_PI_Q32  = 48'd26986075409;
  localparam logic signed [35:0] TWO_PI_S    = 36'sd26986075409;
  localparam logic signed [35:0] PI_Q32      = 36'sd13493037704;
  localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [35:0] GAIN_Q32    = 36'sd2608131496;

  localparam logic signed [35:0] ATAN_Q32 [ATAN_ENTRIES] = '{
    36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
    36'sd268086748, 36'sd134174063, 36'sd67103403, 36'sd33553749,
    36'sd16777131, 36'sd8388597, 36'sd4194303, 36'sd2097152,
    36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072,
    36'sd65536, 36'sd32768, 36'sd16384, 36'sd8192,
    36'sd4096, 36'sd2048, 36'sd1024, 36'sd512,
    36'sd256, 36'sd128, 36'sd64, 36'sd32,
    36'sd16, 36'sd8
  };

endpackage

// ===== rtl/rvxe_sincos.sv =====
// Pipelined angle reduction and CORDIC sine/cosine, Q16.16 in, Q.30 out.
module rvxe_sincos import rvxe_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic signed [31:0] angle,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  logic        [47:0] rem [RED_STAGES+1];
  logic               neg [RED_STAGES+1];
  logic signed [35:0] r1;
  logic               neg1;
  logic signed [35:0] cx [STEPS+1];
  logic signed [35:0] cy [STEPS+1];
  logic signed [35:0] cz [STEPS+1];
  logic               cf [STEPS+1];

  logic        [47:0] ang_w;
  logic signed [35:0] rm;
  logic signed [35:0] rs;
  logic signed [35:0] xf;
  logic signed [35:0] yf;

  assign ang_w = {angle, 16'h0000};

  always_ff @(posedge clk) begin
    neg[0] <= angle[31];
    rem[0] <= angle[31] ? (~ang_w + 48'd1) : ang_w;
  end

  for (genvar j = 0; j < RED_STAGES; j++) begin : g_red
    localparam logic [47:0] D1 = TWO_PI_Q32 << (13 - 2 * j);
    localparam logic [47:0] D2 = TWO_PI_Q32 << (12 - 2 * j);
    logic [47:0] t1;
    logic [47:0] t2;
    always_comb begin
      t1 = (rem[j] >= D1) ? (rem[j] - D1) : rem[j];
      t2 = (t1 >= D2) ? (t1 - D2) : t1;
    end
    always_ff @(posedge clk) begin
      rem[j+1] <= t2;
      neg[j+1] <= neg[j];
    end
  end

  always_comb begin
    rm = signed'({1'b0, rem[RED_STAGES][34:0]});
    rs = neg[RED_STAGES] ? -rm : rm;
  end

  always_ff @(posedge clk) begin
    neg1 <= 1'b0;
    if (rs > PI_Q32) begin
      r1 <= rs - TWO_PI_S;
    end else if (rs < -PI_Q32) begin
      r1 <= rs + TWO_PI_S;
    end else begin
      r1 <= rs;
    end
  end

  always_ff @(posedge clk) begin
    cx[0] <= GAIN_Q32;
    cy[0] <= '0;
    if (r1 > HALF_PI_Q32) begin
      cz[0] <= r1 - PI_Q32;
      cf[0] <= 1'b1;
    end else if (r1 < -HALF_PI_Q32) begin
      cz[0] <= r1 + PI_Q32;
      cf[0] <= 1'b1;
    end else begin
      cz[0] <= r1;
      cf[0] <= neg1;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      cf[i+1] <= cf[i];
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ATAN_Q32[i];
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ATAN_Q32[i];
      end
    end
  end

  always_comb begin
    xf = (cf[STEPS] ? -cx[STEPS] : cx[STEPS]) + 36'sd2;
    yf = (cf[STEPS] ? -cy[STEPS] : cy[STEPS]) + 36'sd2;
  end

  always_ff @(posedge clk) begin
    cos_q30 <= xf[33:2];
    sin_q30 <= yf[33:2];
  end

endmodule

// ===== rtl/rotate_vector_xyz_euler.sv =====
// Top level: Euler X-Y-Z rotation of a Q16.16 vector.
// Throughput: one transfer per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the angle reduction, one CORDIC stage per step and the
// three multiply/round pairs. Synchronous reset clears the valid pipeline only.
module rotate_vector_xyz_euler import rvxe_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  rvxe_in_t  operand,
  output logic      done,
  output rvxe_out_t result
);

  localparam int LS  = CORDIC_STEPS + 11;
  localparam int LAT = LS + 7;

  typedef logic signed [39:0] vec_t;
  typedef logic signed [71:0] prod_t;

  function automatic vec_t rnd(input logic signed [72:0] s);
    logic signed [72:0] t;
    t = s + 73'sd536870912;
    return t[69:30];
  endfunction

  function automatic logic signed [31:0] sat(input vec_t v, output logic c);
    c = 1'b0;
    if (v > 40'sd2147483647) begin
      c = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      c = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic [LS-1:0] vld_sc;
  logic [5:0]    vld_rot;
  logic signed [31:0] crd_x [LS];
  logic signed [31:0] crd_y [LS];
  logic signed [31:0] crd_z [LS];

  logic signed [31:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;

  prod_t p0, p1, p2, p3;
  vec_t  vx0, vx1, vy1, vz1, vx2, vz2, vy2, vx3, vy3, vz3;
  logic signed [31:0] cy1, sy1, cz1, sz1, cy2, sy2, cz2, sz2, cz3, sz3, cz4, sz4;
  logic c0, c1, c2;
  logic signed [31:0] ox, oy, oz;

  assign busy = 1'b0;

  rvxe_sincos #(.STEPS(CORDIC_STEPS)) u_sc_x (
    .clk(clk), .angle(operand.angle_x), .cos_q30(cos_x), .sin_q30(sin_x));
  rvxe_sincos #(.STEPS(CORDIC_STEPS)) u_sc_y (
    .clk(clk), .angle(operand.angle_y), .cos_q30(cos_y), .sin_q30(sin_y));
  rvxe_sincos #(.STEPS(CORDIC_STEPS)) u_sc_z (
    .clk(clk), .angle(operand.angle_z), .cos_q30(cos_z), .sin_q30(sin_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sc  <= '0;
      vld_rot <= '0;
      done    <= 1'b0;
    end else begin
      vld_sc  <= {vld_sc[LS-2:0], start & ~busy};
      vld_rot <= {vld_rot[4:0], vld_sc[LS-1]};
      done    <= vld_rot[5];
    end
  end

  always_ff @(posedge clk) begin
    crd_x[0] <= operand.coord_x;
    crd_y[0] <= operand.coord_y;
    crd_z[0] <= operand.coord_z;
    for (int k = 1; k < LS; k++) begin
      crd_x[k] <= crd_x[k-1];
      crd_y[k] <= crd_y[k-1];
      crd_z[k] <= crd_z[k-1];
    end
  end

  // rotate about x
  always_ff @(posedge clk) begin
    p0  <= 72'(crd_y[LS-1]) * 72'(cos_x);
    p1  <= 72'(crd_z[LS-1]) * 72'(sin_x);
    p2  <= 72'(crd_y[LS-1]) * 72'(sin_x);
    p3  <= 72'(crd_z[LS-1]) * 72'(cos_x);
    vx0 <= 40'(crd_x[LS-1]);
    cy1 <= cos_y;
    sy1 <= sin_y;
    cz1 <= cos_z;
    sz1 <= sin_z;
  end

  always_ff @(posedge clk) begin
    vy1 <= rnd(73'(p0) - 73'(p1));
    vz1 <= rnd(73'(p2) + 73'(p3));
    vx1 <= vx0;
    cy2 <= cy1;
    sy2 <= sy1;
    cz2 <= cz1;
    sz2 <= sz1;
  end

  // rotate about y
  prod_t q0, q1, q2, q3;
  vec_t  vy1d;

  always_ff @(posedge clk) begin
    q0   <= 72'(vx1) * 72'(cy2);
    q1   <= 72'(vz1) * 72'(sy2);
    q2   <= 72'(vx1) * 72'(sy2);
    q3   <= 72'(vz1) * 72'(cy2);
    vy1d <= vy1;
    cz3  <= cz2;
    sz3  <= sz2;
  end

  always_ff @(posedge clk) begin
    vx2 <= rnd(73'(q0) + 73'(q1));
    vz2 <= rnd(73'(q3) - 73'(q2));
    vy2 <= vy1d;
    cz4 <= cz3;
    sz4 <= sz3;
  end

  // rotate about z
  prod_t w0, w1, w2, w3;
  vec_t  vz2d;

  always_ff @(posedge clk) begin
    w0   <= 72'(vx2) * 72'(cz4);
    w1   <= 72'(vy2) * 72'(sz4);
    w2   <= 72'(vx2) * 72'(sz4);
    w3   <= 72'(vy2) * 72'(cz4);
    vz2d <= vz2;
  end

  always_ff @(posedge clk) begin
    vx3 <= rnd(73'(w0) - 73'(w1));
    vy3 <= rnd(73'(w2) + 73'(w3));
    vz3 <= vz2d;
  end

  always_comb begin
    ox = sat(vx3, c0);
    oy = sat(vy3, c1);
    oz = sat(vz3, c2);
  end

  always_ff @(posedge clk) begin
    result.rotated_x <= ox;
    result.rotated_y <= oy;
    result.rotated_z <= oz;
    result.clipped   <= c0 | c1 | c2;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transfer did not complete after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without matching transfer");

  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    (done && !result.clipped) |-> $past(vx3 == 40'(ox) && vy3 == 40'(oy) && vz3 == 40'(oz)))
    else $error("unclipped result differs from rotated vector");

endmodule

// ===== tb/sv/rotate_vector_xyz_euler_checker.sv =====
// Checker for the Euler XYZ rotation block: predicts each result and compares it.
`timescale 1ns / 100ps
module rotate_vector_xyz_euler_checker import rvxe_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  rvxe_in_t  operand,
  input  logic      done,
  input  rvxe_out_t result,
  output int        fail_count,
  output int        pending,
  output int        result_count,
  output int        clip_count
);

  localparam longint TWO_PI_L  = 64'sd26986075409;
  localparam longint PI_L      = 64'sd13493037704;
  localparam longint HALF_PI_L = 64'sd6746518852;
  localparam longint GAIN_L    = 64'sd2608131496;

  localparam longint ATAN_L [30] = '{
    64'sd3373259426, 1991351318, 1052175346, 534100635, 268086748,
    134174063, 67103403, 33553749, 16777131, 8388597,
    4194303, 2097152, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8
  };

  rvxe_out_t rotated_q[$];

  function automatic void sin_cos(input longint ang, output longint c30, output longint s30);
    longint r, x, y, dx, dy;
    bit flip;
    r = (ang * 65536) % TWO_PI_L;
    flip = 0;
    x = GAIN_L;
    y = 0;
    if (r > PI_L) r -= TWO_PI_L;
    else if (r < -PI_L) r += TWO_PI_L;
    if (r > HALF_PI_L) begin
      r -= PI_L; flip = 1;
    end else if (r < -HALF_PI_L) begin
      r += PI_L; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= ATAN_L[i];
      end else begin
        x += dx; y -= dy; r += ATAN_L[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c30 = (x + 2) >>> 2;
    s30 = (y + 2) >>> 2;
  endfunction

  function automatic longint mac_round(longint a, longint p, longint b, longint q);
    return (a * p + b * q + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, ref bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1; return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clip = 1; return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic rvxe_out_t rotate_xyz(rvxe_in_t op);
    longint x, y, z, c, s, t0, t1;
    bit clip;
    rvxe_out_t r;
    x = op.coord_x;
    y = op.coord_y;
    z = op.coord_z;
    clip = 0;
    sin_cos(op.angle_x, c, s);
    t0 = mac_round(y, c, z, -s);
    t1 = mac_round(y, s, z, c);
    y = t0; z = t1;
    sin_cos(op.angle_y, c, s);
    t0 = mac_round(x, c, z, s);
    t1 = mac_round(x, -s, z, c);
    x = t0; z = t1;
    sin_cos(op.angle_z, c, s);
    t0 = mac_round(x, c, y, -s);
    t1 = mac_round(x, s, y, c);
    x = t0; y = t1;
    r.rotated_x = clamp32(x, clip);
    r.rotated_y = clamp32(y, clip);
    r.rotated_z = clamp32(z, clip);
    r.clipped   = clip;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    clip_count = 0;
  end

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    rvxe_out_t exp_r;
    if (!rst) begin
      if (done) begin
        result_count++;
        if (rotated_q.size() == 0) begin
          report_mismatch("result with no transfer waiting");
        end else begin
          exp_r = rotated_q.pop_front();
          if (exp_r.clipped) clip_count++;
          if (result.rotated_x !== exp_r.rotated_x)
            report_mismatch($sformatf("rotated_x %0d, want %0d", result.rotated_x,
                                      exp_r.rotated_x));
          if (result.rotated_y !== exp_r.rotated_y)
            report_mismatch($sformatf("rotated_y %0d, want %0d", result.rotated_y,
                                      exp_r.rotated_y));
          if (result.rotated_z !== exp_r.rotated_z)
            report_mismatch($sformatf("rotated_z %0d, want %0d", result.rotated_z,
                                      exp_r.rotated_z));
          if (result.clipped !== exp_r.clipped)
            report_mismatch($sformatf("clipped %0b, want %0b", result.clipped,
                                      exp_r.clipped));
        end
      end
      if (start && !busy) rotated_q.push_back(rotate_xyz(operand));
    end
  end

endmodule

// ===== tb/sv/rotate_vector_xyz_euler_test.sv =====
// Testbench top for the Euler XYZ rotation block: stimulus, timeout and verdict.
`timescale 1ns / 100ps
module rotate_vector_xyz_euler_test;
  import rvxe_pkg::*;

  localparam int  LATENCY   = 16 + 18;
  localparam int  N_RANDOM  = 1630;
  localparam longint CYCLE_LIMIT = 200000;

  logic      clk = 0;
  logic      rst = 1;
  logic      start = 0;
  logic      busy;
  rvxe_in_t  operand = '0;
  logic      done;
  rvxe_out_t result;
  int        fail_count, pending, result_count, clip_count;
  longint    cycles = 0;
  int        sent = 0;

  always #5 clk = ~clk;

  rotate_vector_xyz_euler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand(operand), .done(done), .result(result)
  );

  rotate_vector_xyz_euler_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operand(operand),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending),
    .result_count(result_count), .clip_count(clip_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** rotate_vector_xyz_euler: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 32'h01000000)) - 32'sh00800000);
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h000c9100)) - 32'sh00064880);
      2: return $urandom_range(0, 3) * 32'h0001921f;
      default: return 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
    endcase
  endfunction

  // hold start high until the transfer is taken
  task automatic send(input rvxe_in_t op);
    start   <= 1;
    operand <= op;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle(input int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    rvxe_in_t op;
    logic [31:0] pat [6];
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    pat = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000,
            32'h0001921f};
    for (int i = 0; i < 6; i++) begin
      op = '{pat[i], pat[(i + 1) % 6], pat[(i + 2) % 6], pat[(i + 3) % 6],
             pat[(i + 4) % 6], pat[(i + 5) % 6]};
      send(op);
    end
    send('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0000c910, 32'h0000c910,
           32'h0000c910});
    send('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
           32'h80000000});
    send('{32'h00010000, 32'h00020000, 32'h00030000, 32'h0003243f, 32'hfffcdbc1,
           32'h0001921f});
    send('{32'h00010000, 32'h00000000, 32'h00000000, 32'h0006487f, 32'h00064880,
           32'hfff9b780});
    send('{32'h00010000, 32'h00010000, 32'h00010000, 32'h000c90fe, 32'h00000000,
           32'h00000000});
    send('{32'h12345678, 32'hedcba987, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
           32'h7ffffffe});

    // pause until every transfer has come back
    idle(1);
    wait (pending == 0);
    @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      op = '{pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle(),
             pick_angle()};
      if (n < N_RANDOM - 200 && $urandom_range(0, 3) == 0) idle($urandom_range(1, 5));
      send(op);
      if (n == N_RANDOM / 2) begin
        idle(1);
        wait (pending == 0);
      end
    end
    idle(1);

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("%0d vectors sent, %0d results checked, %0d with saturation", sent,
             result_count, clip_count);
    $display("covered extreme coordinates, multiples of pi/2 and wide angles");
    if (fail_count == 0) begin
      $display("** rotate_vector_xyz_euler: PASSED **");
    end else begin
      $display("** rotate_vector_xyz_euler: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rvxe_pkg.sv
rtl/rvxe_sincos.sv
rtl/rotate_vector_xyz_euler.sv
tb/sv/rotate_vector_xyz_euler_checker.sv
tb/sv/rotate_vector_xyz_euler_test.sv
